// ===== src/rpmd_pkg.sv =====
// shared types and constants of the range presence and motion detector
`default_nettype none
package rpmd_pkg;

    localparam int unsigned DistW  = 16;
    localparam int unsigned DeltaW = DistW + 1;
    localparam int unsigned TimerW = 17;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 16;

    localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};

    // configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_NEAR_THRESHOLD = 3'd0,
        REG_FAR_LIMIT      = 3'd1,
        REG_MOTION_MARGIN  = 3'd2,
        REG_HOLD_TIME      = 3'd3,
        REG_POLL_PERIOD    = 3'd4,
        REG_NEAR_ENABLE    = 3'd5,
        REG_MOTION_ENABLE  = 3'd6
    } t_reg_idx;

    // reset values of the registers
    localparam logic [DistW-1:0] NearThresholdRst = 16'd200;
    localparam logic [DistW-1:0] FarLimitRst      = 16'd1000;
    localparam logic [DistW-1:0] MotionMarginRst  = 16'd50;
    localparam logic [DistW-1:0] HoldTimeRst      = 16'd1000;
    localparam logic [DistW-1:0] PollPeriodRst    = 16'd100;

    typedef struct packed {
        logic [DistW-1:0] near_threshold;
        logic [DistW-1:0] far_limit;
        logic [DistW-1:0] motion_margin;
        logic [DistW-1:0] hold_time_ms;
        logic [DistW-1:0] poll_period_ms;
        logic             near_enable;
        logic             motion_enable;
    } t_cfg;

    typedef struct packed {
        logic [DistW-1:0]         prev_distance;
        logic signed [DeltaW-1:0] prev_delta;
        logic                     near;
        logic                     motion;
        logic [TimerW-1:0]        since_motion;
    } t_state;

    typedef struct packed {
        logic [DistW-1:0] clamped_distance;
        logic             near_flag;
        logic             near_changed;
        logic             motion_flag;
        logic             motion_changed;
    } t_result;

endpackage
`default_nettype wire

// ===== src/rpmd_in_if.sv =====
// input channel: one distance sample word
`default_nettype none
interface rpmd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] distance_mm;
    logic        force_report;

    modport source (output valid, output distance_mm, output force_report, input ready);
    modport sink (input valid, input distance_mm, input force_report, output ready);
endinterface
`default_nettype wire

// ===== src/rpmd_out_if.sv =====
// output channel: one detector result word
`default_nettype none
interface rpmd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] clamped_distance;
    logic        near_flag;
    logic        near_changed;
    logic        motion_flag;
    logic        motion_changed;

    modport source (
        output valid, output clamped_distance, output near_flag, output near_changed,
        output motion_flag, output motion_changed, input ready
    );
    modport sink (
        input valid, input clamped_distance, input near_flag, input near_changed,
        input motion_flag, input motion_changed, output ready
    );
endinterface
`default_nettype wire

// ===== src/rpmd_step.sv =====
// combinational update of the detector state for one sample
`default_nettype none
module rpmd_step (
    input  wire rpmd_pkg::t_cfg    i_cfg,
    input  wire rpmd_pkg::t_state  i_state,
    input  wire logic [15:0]       i_distance,
    input  wire logic              i_force,
    output rpmd_pkg::t_state       o_state,
    output rpmd_pkg::t_result      o_result
);
    import rpmd_pkg::*;

    logic [DistW-1:0]         range_mm;
    logic [TimerW:0]          timer_sum;
    logic [TimerW-1:0]        timer_adv;
    logic                     both_below;
    logic                     both_above;
    logic signed [DeltaW-1:0] delta;
    logic signed [DeltaW+1:0] delta_sum;
    logic signed [DeltaW+1:0] margin_pos;
    logic signed [DeltaW+1:0] margin_neg;
    logic                     motion_hit;

    // clamp to the far limit
    assign range_mm = (i_distance > i_cfg.far_limit) ? i_cfg.far_limit : i_distance;

    // hold timer, saturating
    assign timer_sum = {1'b0, i_state.since_motion} + {{(TimerW+1-DistW){1'b0}}, i_cfg.poll_period_ms};
    assign timer_adv = timer_sum[TimerW] ? TimerMax : timer_sum[TimerW-1:0];

    // near comparisons on this and the previous sample
    assign both_below = (range_mm < i_cfg.near_threshold)
                     && (i_state.prev_distance < i_cfg.near_threshold);
    assign both_above = (range_mm > i_cfg.near_threshold)
                     && (i_state.prev_distance > i_cfg.near_threshold);

    // two-step movement
    assign delta      = $signed({1'b0, range_mm}) - $signed({1'b0, i_state.prev_distance});
    assign delta_sum  = {{2{delta[DeltaW-1]}}, delta}
                      + {{2{i_state.prev_delta[DeltaW-1]}}, i_state.prev_delta};
    assign margin_pos = $signed({{(DeltaW+2-DistW){1'b0}}, i_cfg.motion_margin});
    assign margin_neg = -margin_pos;
    assign motion_hit = ((delta > 0) && (i_state.prev_delta > 0) && (delta_sum >= margin_pos))
                     || ((delta < 0) && (i_state.prev_delta < 0) && (delta_sum <= margin_neg));

    // next state and result
    always_comb begin
        o_state = i_state;
        o_state.prev_distance = range_mm;
        o_state.since_motion  = timer_adv;
        o_result.clamped_distance = range_mm;
        o_result.near_changed   = 1'b0;
        o_result.motion_changed = 1'b0;

        if (i_cfg.near_enable) begin
            o_result.near_changed = i_force;
            if (both_below) begin
                if (!i_state.near) begin
                    o_state.near = 1'b1;
                    o_result.near_changed = 1'b1;
                end
            end else if (both_above) begin
                if (i_force || i_state.near) begin
                    o_state.near = 1'b0;
                    o_result.near_changed = 1'b1;
                end
            end
        end

        if (i_cfg.motion_enable) begin
            o_result.motion_changed = i_force;
            if (motion_hit) begin
                if (!i_state.motion) begin
                    o_state.motion = 1'b1;
                    o_result.motion_changed = 1'b1;
                end
                o_state.since_motion = '0;
            end else if (timer_adv > {{(TimerW-DistW){1'b0}}, i_cfg.hold_time_ms}) begin
                if (i_state.motion) begin
                    o_state.motion = 1'b0;
                    o_result.motion_changed = 1'b1;
                end
            end
            o_state.prev_delta = delta;
        end

        o_result.near_flag   = o_state.near;
        o_result.motion_flag = o_state.motion;
    end

endmodule
`default_nettype wire

// ===== src/range_presence_motion_detector.sv =====
// Range presence and motion detector, top level. Each word on the input channel is one
// distance sample; one result word comes out per sample, after the sample has passed the
// input register and then the result register. A sample can be taken every cycle while
// the output does not stall: the whole update is one pass of compare and add logic between
// the two registers. A waiting result holds up new samples only once the input register is
// full as well. Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data
// and should only be changed while no sample is in flight.
`default_nettype none
module range_presence_motion_detector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rpmd_pkg::CfgIdxW-1:0]       i_cfg_idx,
    input  wire logic [rpmd_pkg::CfgDataW-1:0]      i_cfg_data,
    rpmd_in_if.sink                                 i_in,
    rpmd_out_if.source                              o_out
);
    import rpmd_pkg::*;

    t_cfg             r_cfg;
    t_state           r_state;
    t_state           n_state;
    t_result          r_out;
    t_result          n_out;
    logic             r_in_valid;
    logic [DistW-1:0] r_in_distance;
    logic             r_in_force;
    logic             r_out_valid;
    logic             advance;
    logic             load;
    logic             in_ready;

    // handshake
    assign advance  = !r_out_valid || o_out.ready;
    assign load     = r_in_valid && advance;
    assign in_ready = !r_in_valid || advance;
    assign i_in.ready = in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_threshold <= NearThresholdRst;
            r_cfg.far_limit      <= FarLimitRst;
            r_cfg.motion_margin  <= MotionMarginRst;
            r_cfg.hold_time_ms   <= HoldTimeRst;
            r_cfg.poll_period_ms <= PollPeriodRst;
            r_cfg.near_enable    <= 1'b1;
            r_cfg.motion_enable  <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_NEAR_THRESHOLD: r_cfg.near_threshold <= i_cfg_data;
                REG_FAR_LIMIT:      r_cfg.far_limit      <= i_cfg_data;
                REG_MOTION_MARGIN:  r_cfg.motion_margin  <= i_cfg_data;
                REG_HOLD_TIME:      r_cfg.hold_time_ms   <= i_cfg_data;
                REG_POLL_PERIOD:    r_cfg.poll_period_ms <= i_cfg_data;
                REG_NEAR_ENABLE:    r_cfg.near_enable    <= i_cfg_data[0];
                REG_MOTION_ENABLE:  r_cfg.motion_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_distance <= i_in.distance_mm;
            r_in_force    <= i_in.force_report;
        end
    end

    // per-sample update
    rpmd_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_distance (r_in_distance),
        .i_force    (r_in_force),
        .o_state    (n_state),
        .o_result   (n_out)
    );

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prev_distance <= '0;
            r_state.prev_delta    <= '0;
            r_state.near          <= 1'b0;
            r_state.motion        <= 1'b0;
            r_state.since_motion  <= TimerMax;
        end else if (load) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.clamped_distance = r_out.clamped_distance;
    assign o_out.near_flag        = r_out.near_flag;
    assign o_out.near_changed     = r_out.near_changed;
    assign o_out.motion_flag      = r_out.motion_flag;
    assign o_out.motion_changed   = r_out.motion_changed;

`ifndef ASSERT_OFF
    // a stalled result with a full input register must block new words
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && r_in_valid) |-> !i_in.ready)
        else $error("input taken while both stages full");

    // a loaded word always shows up on the output next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_out_valid)
        else $error("loaded word not presented");

    // motion only sets together with a timer restart
    a_motion_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state.motion) |-> (r_state.since_motion == '0))
        else $error("motion set without timer restart");

    // the near flag only clears while the near detector is enabled
    a_near_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_state.near)) |-> $past(r_cfg.near_enable))
        else $error("near flag cleared while disabled");
`endif

endmodule
`default_nettype wire
